>>> rtl/gcd_pkg.sv
// Shared constants, types and arctangent table for the great-circle distance pipeline.
`timescale 1ns / 1ps

package gcd_pkg;

  // Default build parameters
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 20;

  // Datapath widths
  localparam int CW     = 34;  // CORDIC x/y/z, Q30 with headroom
  localparam int ROOT_W = 31;  // square root of a value up to 2^60
  localparam int SQ_W   = 61;  // remainder of the square root

  // Angle constants in degrees * 65536
  localparam logic signed [26:0] DEG_FULL    = 27'sd23592960;
  localparam logic signed [26:0] DEG_HALF    = 27'sd11796480;
  localparam logic signed [26:0] DEG_QUARTER = 27'sd5898240;
  localparam logic signed [26:0] DEG_3QUARTER = 27'sd17694720;

  // Degree to radian conversion: pi*2^29 = 45*CONV_Q + 13
  localparam logic [25:0] CONV_Q     = 26'd37480660;
  localparam logic [23:0] RECIP_45   = 24'd11930465;  // ceil(2^29 / 45)
  localparam logic [10:0] RECIP_45_S = 11'd1457;      // ceil(2^16 / 45)

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [34:0]   PI_Q30   = 35'sd3373259426;
  localparam logic signed [32:0]   ONE_Q30  = 33'sd1073741824;
  localparam logic [SQ_W-1:0]      ONE_SQ   = 61'd1 << 60;

  localparam logic [15:0] RADIUS_RESET = 16'd6371;
  localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;
  localparam logic [17:0] ANGLE_MAX    = 18'h3FFFF;

  // Tag carried through the square root cells
  typedef struct packed {
    logic              clamped;
    logic              cneg;
    logic [ROOT_W-1:0] ac;
  } sq_tag_t;

  // Tag carried through the arc cosine cells
  typedef struct packed {
    logic clamped;
    logic cneg;
  } ac_tag_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/great_circle_distance_top.sv
// Top level of the great-circle distance pipeline.
`timescale 1ns / 1ps
//
// Great-circle distance by the spherical law of cosines.
// Input channel (in_valid/in_ready) carries one point pair per word: two
// latitudes and two longitudes in degrees * 65536. Output channel
// (out_valid/out_ready) carries distance_km (km * 256), central_angle
// (radians * 2^ANGLE_FRAC_BITS) and was_clamped.
// Throughput: one word per cycle while the output is not stalled. The
// path runs through the chain of CORDIC cells for sine/cosine, the 31 square
// root cells and the chain of arc cosine CORDIC cells.
// The whole chain advances together; a stalled receiver freezes every
// stage, and in_ready drops only while a result waits at the output and
// out_ready is low. Reset clears all valid flags and sets the radius to
// 6371 km. The radius is written through cfg_we/cfg_wdata; the user must
// write it only while no word is in flight; the block does not enforce it.
//
module great_circle_distance_top import gcd_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] first_latitude,
  input  logic signed [24:0] first_longitude,
  input  logic signed [23:0] second_latitude,
  input  logic signed [24:0] second_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        distance_km,
  output logic [17:0]        central_angle,
  output logic               was_clamped,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = 46 + 2 * N;
  localparam int SH  = 30 - ANGLE_FRAC_BITS;

  logic           en;
  logic [LAT-1:0] vld;
  logic [15:0]    radius;

  // Advance everything unless a result waits
  assign en        = ~out_valid | out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // Capture the word
  logic signed [25:0] ang_in [3];

  always_ff @(posedge clk) begin
    if (en) begin
      ang_in[0] <= 26'(first_latitude);
      ang_in[1] <= 26'(second_latitude);
      ang_in[2] <= 26'(first_longitude) - 26'(second_longitude);
    end
  end

  // Angle conversion and sine/cosine chains
  logic signed [CW-1:0] rx [3][N+1];
  logic signed [CW-1:0] ry [3][N+1];
  logic signed [CW-1:0] rz [3][N+1];
  logic                 rt [3][N+1];

  for (genvar c = 0; c < 3; c++) begin : g_sc
    gcd_angle_conv u_conv (
      .clk     (clk),
      .en      (en),
      .deg     (ang_in[c]),
      .z       (rz[c][0]),
      .neg_cos (rt[c][0])
    );
    assign rx[c][0] = GAIN_Q30;
    assign ry[c][0] = '0;
    for (genvar i = 0; i < N; i++) begin : g_cell
      gcd_cordic_cell #(.STAGE(i), .VECTOR(1'b0), .TAG_W(1)) u_cell (
        .clk    (clk),
        .en     (en),
        .x_in   (rx[c][i]),
        .y_in   (ry[c][i]),
        .z_in   (rz[c][i]),
        .tag_in (rt[c][i]),
        .x      (rx[c][i+1]),
        .y      (ry[c][i+1]),
        .z      (rz[c][i+1]),
        .tag    (rt[c][i+1])
      );
    end
  end

  // Final sines and cosines
  logic signed [31:0] s1, c1, s2, c2, cd;
  logic signed [CW-1:0] c1_raw, c2_raw, cd_raw;

  assign c1_raw = rt[0][N] ? -rx[0][N] : rx[0][N];
  assign c2_raw = rt[1][N] ? -rx[1][N] : rx[1][N];
  assign cd_raw = rt[2][N] ? -rx[2][N] : rx[2][N];

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= ry[0][N][31:0];
      s2 <= ry[1][N][31:0];
      c1 <= c1_raw[31:0];
      c2 <= c2_raw[31:0];
      cd <= cd_raw[31:0];
    end
  end

  // Latitude products
  logic signed [63:0] p_ss, p_cc, p_tc;
  logic signed [31:0] ss1, cc1, cd1, ss2, tc2;

  assign p_ss = 64'(s1) * 64'(s2);
  assign p_cc = 64'(c1) * 64'(c2);

  always_ff @(posedge clk) begin
    if (en) begin
      ss1 <= p_ss[61:30];
      cc1 <= p_cc[61:30];
      cd1 <= cd;
    end
  end

  // Longitude term
  assign p_tc = 64'(cc1) * 64'(cd1);

  always_ff @(posedge clk) begin
    if (en) begin
      ss2 <= ss1;
      tc2 <= p_tc[61:30];
    end
  end

  // Sum and clamp into [-1, 1]
  logic signed [32:0] cos_sum;
  logic signed [32:0] cosd_next;
  logic               clamp_next;
  logic signed [31:0] cosd;
  logic               clamped3;

  assign cos_sum = 33'(ss2) + 33'(tc2);
  always_comb begin
    clamp_next = 1'b0;
    if (cos_sum > ONE_Q30) begin
      cosd_next  = ONE_Q30;
      clamp_next = 1'b1;
    end else if (cos_sum < -ONE_Q30) begin
      cosd_next  = -ONE_Q30;
      clamp_next = 1'b1;
    end else begin
      cosd_next = cos_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cosd     <= cosd_next[31:0];
      clamped3 <= clamp_next;
    end
  end

  // Square of the magnitude
  logic [ROOT_W-1:0] ac_next, ac4, ac5;
  logic [61:0]       acsq_prod;
  logic [SQ_W-1:0]   acsq4, rem5;
  logic              cneg4, clamped4, cneg5, clamped5;

  assign ac_next   = cosd[31] ? ROOT_W'(-cosd) : cosd[ROOT_W-1:0];
  assign acsq_prod = 62'(ac_next) * 62'(ac_next);

  always_ff @(posedge clk) begin
    if (en) begin
      ac4      <= ac_next;
      acsq4    <= acsq_prod[SQ_W-1:0];
      cneg4    <= cosd[31];
      clamped4 <= clamped3;
    end
  end

  // Remainder under the root
  always_ff @(posedge clk) begin
    if (en) begin
      rem5     <= ONE_SQ - acsq4;
      ac5      <= ac4;
      cneg5    <= cneg4;
      clamped5 <= clamped4;
    end
  end

  // Square root chain, one root bit per cell
  logic [ROOT_W-1:0] sq_q   [ROOT_W+1];
  logic [SQ_W-1:0]   sq_rem [ROOT_W+1];
  sq_tag_t           sq_tag [ROOT_W+1];

  assign sq_q[0]   = '0;
  assign sq_rem[0] = rem5;
  assign sq_tag[0] = '{clamped: clamped5, cneg: cneg5, ac: ac5};

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    gcd_sqrt_cell #(.K(ROOT_W - 1 - j)) u_cell (
      .clk    (clk),
      .en     (en),
      .q_in   (sq_q[j]),
      .rem_in (sq_rem[j]),
      .tag_in (sq_tag[j]),
      .q      (sq_q[j+1]),
      .rem    (sq_rem[j+1]),
      .tag    (sq_tag[j+1])
    );
  end

  // Arc cosine chain
  logic signed [CW-1:0] vx [N+1];
  logic signed [CW-1:0] vy [N+1];
  logic signed [CW-1:0] vz [N+1];
  logic [1:0]           vt [N+1];
  ac_tag_t              vt_end;

  assign vx[0] = $signed({{(CW-ROOT_W){1'b0}}, sq_tag[ROOT_W].ac});
  assign vy[0] = $signed({{(CW-ROOT_W){1'b0}}, sq_q[ROOT_W]});
  assign vz[0] = '0;
  assign vt[0] = {sq_tag[ROOT_W].clamped, sq_tag[ROOT_W].cneg};

  for (genvar i = 0; i < N; i++) begin : g_acos
    gcd_cordic_cell #(.STAGE(i), .VECTOR(1'b1), .TAG_W(2)) u_cell (
      .clk    (clk),
      .en     (en),
      .x_in   (vx[i]),
      .y_in   (vy[i]),
      .z_in   (vz[i]),
      .tag_in (vt[i]),
      .x      (vx[i+1]),
      .y      (vy[i+1]),
      .z      (vz[i+1]),
      .tag    (vt[i+1])
    );
  end

  assign vt_end = vt[N];

  // Reflect for a negative cosine, floor at zero
  logic signed [34:0] ang_full;
  logic [32:0]        ang;
  logic               clamped_a1;

  assign ang_full = vt_end.cneg ? PI_Q30 - 35'(vz[N]) : 35'(vz[N]);

  always_ff @(posedge clk) begin
    if (en) begin
      ang        <= ang_full[34] ? 33'd0 : ang_full[32:0];
      clamped_a1 <= vt_end.clamped;
    end
  end

  // Round the angle, scale by the radius
  logic [33:0] ca_sum;
  logic [48:0] dist_prod;
  logic [17:0] ca_a2;
  logic        clamped_a2;
  logic [48:0] prod_a2;

  assign ca_sum    = (34'(ang) + (34'd1 << (SH - 1))) >> SH;
  assign dist_prod = 49'(ang) * 49'(radius);

  always_ff @(posedge clk) begin
    if (en) begin
      ca_a2      <= (ca_sum > 34'(ANGLE_MAX)) ? ANGLE_MAX : ca_sum[17:0];
      clamped_a2 <= clamped_a1;
      prod_a2    <= dist_prod;
    end
  end

  // Round and saturate the distance
  logic [49:0] dist_sum;

  assign dist_sum = (50'(prod_a2) + 50'(1 << 21)) >> 22;

  always_ff @(posedge clk) begin
    if (en) begin
      distance_km   <= (dist_sum > 50'(DIST_MAX)) ? DIST_MAX : dist_sum[23:0];
      central_angle <= ca_a2;
      was_clamped   <= clamped_a2;
    end
  end

endmodule

>>> rtl/gcd_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode, with a registered output.
`timescale 1ns / 1ps

module gcd_cordic_cell import gcd_pkg::*; #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0,
  parameter int TAG_W  = 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [CW-1:0]  x_in,
  input  logic signed [CW-1:0]  y_in,
  input  logic signed [CW-1:0]  z_in,
  input  logic [TAG_W-1:0]      tag_in,
  output logic signed [CW-1:0]  x,
  output logic signed [CW-1:0]  y,
  output logic signed [CW-1:0]  z,
  output logic [TAG_W-1:0]      tag
);

  localparam logic signed [CW-1:0] ATAN = $signed({{(CW-30){1'b0}}, atan_q30(STAGE)});

  logic signed [CW-1:0] dx, dy;
  logic                 pos, sub;

  // Pick the rotation direction
  assign dx  = y_in >>> STAGE;
  assign dy  = x_in >>> STAGE;
  assign pos = VECTOR ? ~y_in[CW-1] : ~z_in[CW-1];
  assign sub = VECTOR ? ~pos : pos;

  // Rotate and hand on
  always_ff @(posedge clk) begin
    if (en) begin
      if (sub) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ATAN;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ATAN;
      end
      tag <= tag_in;
    end
  end

endmodule

>>> rtl/gcd_sqrt_cell.sv
// One bit of a restoring integer square root, with a registered output.
`timescale 1ns / 1ps

module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int K = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] q_in,
  input  logic [SQ_W-1:0]   rem_in,
  input  sq_tag_t           tag_in,
  output logic [ROOT_W-1:0] q,
  output logic [SQ_W-1:0]   rem,
  output sq_tag_t           tag
);

  logic [62:0] trial;
  logic        take;

  // (q + 2^K)^2 - q^2
  assign trial = (63'(q_in) << (K + 1)) + (63'd1 << (2 * K));
  assign take  = {2'b00, rem_in} >= trial;

  // Accept or drop this root bit
  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        rem <= rem_in - trial[SQ_W-1:0];
        q   <= q_in | (ROOT_W'(1) << K);
      end else begin
        rem <= rem_in;
        q   <= q_in;
      end
      tag <= tag_in;
    end
  end

endmodule

>>> rtl/gcd_angle_conv.sv
// Wraps and folds an angle in degrees and converts it to Q30 radians over five stages.
`timescale 1ns / 1ps

module gcd_angle_conv import gcd_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [25:0]   deg,
  output logic signed [CW-1:0] z,
  output logic                 neg_cos
);

  logic signed [26:0] a_ext, w_next;
  logic [24:0]        w;
  logic signed [26:0] ws, fold_next;
  logic               fold_neg;
  logic signed [23:0] a2;
  logic               neg2;
  logic [22:0]        mag_next, mag3;
  logic [46:0]        m1_prod;
  logic [17:0]        m13;
  logic               sgn3, neg3;
  logic [48:0]        a_prod, a4;
  logic [22:0]        m0_full;
  logic [5:0]         m0;
  logic [19:0]        f_prod;
  logic [21:0]        t45_next, t45;
  logic               sgn4, neg4;
  logic [48:0]        b_sum;

  // Wrap into [0, 360) degrees
  assign a_ext = {deg[25], deg};
  always_comb begin
    if (a_ext < -DEG_FULL) begin
      w_next = a_ext + DEG_FULL + DEG_FULL;
    end else if (a_ext < 27'sd0) begin
      w_next = a_ext + DEG_FULL;
    end else if (a_ext >= DEG_FULL) begin
      w_next = a_ext - DEG_FULL;
    end else begin
      w_next = a_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w <= w_next[24:0];
    end
  end

  // Recenter to (-180, 180] and fold into [-90, 90]
  assign ws = $signed({2'b00, w});
  always_comb begin
    fold_neg = 1'b0;
    if (ws > DEG_QUARTER && ws < DEG_3QUARTER) begin
      fold_next = DEG_HALF - ws;
      fold_neg  = 1'b1;
    end else if (ws > DEG_HALF) begin
      fold_next = ws - DEG_FULL;
    end else begin
      fold_next = ws;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2   <= fold_next[23:0];
      neg2 <= fold_neg;
    end
  end

  // Magnitude and its quotient by 45
  assign mag_next = a2[23] ? 23'(-a2) : a2[22:0];
  assign m1_prod  = 47'(mag_next) * 47'(RECIP_45);

  always_ff @(posedge clk) begin
    if (en) begin
      mag3 <= mag_next;
      m13  <= m1_prod[46:29];
      sgn3 <= a2[23];
      neg3 <= neg2;
    end
  end

  // Main product and the small correction term
  assign a_prod   = 49'(mag3) * 49'(CONV_Q);
  assign m0_full  = mag3 - 23'(m13) * 23'd45;
  assign m0       = m0_full[5:0];
  assign f_prod   = 20'(m0) * 20'd13 * 20'(RECIP_45_S);
  assign t45_next = 22'(m13) * 22'd13 + 22'd65536 + 22'(f_prod[19:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      a4   <= a_prod;
      t45  <= t45_next;
      sgn4 <= sgn3;
      neg4 <= neg3;
    end
  end

  // Sum, scale and apply sign
  assign b_sum = a4 + 49'(t45);

  always_ff @(posedge clk) begin
    if (en) begin
      z       <= sgn4 ? -$signed({3'b000, b_sum[47:17]}) : $signed({3'b000, b_sum[47:17]});
      neg_cos <= neg4;
    end
  end

endmodule

>>> rtl/gcd_checker.sv
// Port-level checks for the great-circle distance top level, bound to it.
`timescale 1ns / 1ps

module gcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] distance_km,
  input logic [17:0] central_angle,
  input logic        was_clamped
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_km) &&
      $stable(central_angle) && $stable(was_clamped))
    else $error("output word changed while stalled");

  // Input stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // Drop every result on reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .distance_km   (distance_km),
  .central_angle (central_angle),
  .was_clamped   (was_clamped)
);
